// ===== src/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== src/bmi_pkg.sv =====
`timescale 1ns / 1ps

package bmi_pkg;

    localparam int QW = 12;
    localparam int AW_IN = 17;
    localparam int PW = 24;
    localparam int BarrettShift = 36;
    localparam int BarrettMW = 25;
    localparam int BatchDefault = 288;

    localparam logic [QW-1:0] ModQ = 12'd3457;
    localparam logic [QW-1:0] ExpQm2 = 12'd3455;
    localparam logic [AW_IN-1:0] CanonOffset = 17'd1802;
    localparam logic [BarrettMW-1:0] BarrettM =
        BarrettMW'((64'd1 << BarrettShift) / 64'd3457);

    // request to the shared modular multiplier
    typedef struct packed {
        logic             go;
        logic             canon;   // reduce a alone instead of a*b
        logic [AW_IN-1:0] a;
        logic [QW-1:0]    b;
    } t_mm_req;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] result;
    } t_mm_rsp;

endpackage

// ===== src/batch_modular_inverse_q3457.sv =====
// a load makes one pass of the shared modular multiplier for reduction and one for the
//   running product; the first element of a batch needs only the reduction pass
// after the last load the inversion runs with busy high: an exponentiation of the running product, then a backward pass
// reads take one transaction per cycle, each result strobed in the cycle after acceptance
// reset (synchronous, active low) returns to loading with empty counts; stores keep data
`timescale 1ns / 1ps

module batch_modular_inverse_q3457 #(
    parameter int BATCH = bmi_pkg::BatchDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_func,
    input  logic signed [15:0]     i_value,
    output logic                   o_strobe,
    output logic [bmi_pkg::QW-1:0] o_inverse,
    output logic                   o_fail,
    output logic                   o_last
);
    import bmi_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(BATCH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CANON = 4'd1;
    localparam logic [3:0] S_PREF  = 4'd2;
    localparam logic [3:0] S_ESQR  = 4'd3;
    localparam logic [3:0] S_EMUL  = 4'd4;
    localparam logic [3:0] S_BRD   = 4'd5;
    localparam logic [3:0] S_BMUL  = 4'd6;
    localparam logic [3:0] S_BW1   = 4'd7;
    localparam logic [3:0] S_BW2   = 4'd8;

    localparam logic PH_LOAD = 1'b0;
    localparam logic PH_READ = 1'b1;

    logic [3:0]    r_state, n_state;
    logic          r_phase, n_phase;
    logic [AW-1:0] r_ld_cnt, n_ld_cnt;
    logic [AW-1:0] r_rd_cnt, n_rd_cnt;
    logic [AW-1:0] r_idx, n_idx;
    logic [3:0]    r_bit, n_bit;
    logic [QW-1:0] r_acc, n_acc;
    logic [QW-1:0] r_prev, n_prev;
    logic [QW-1:0] r_elem, n_elem;
    logic          r_fail, n_fail;
    logic          r_out_vld, n_out_vld;
    logic          r_out_fail, n_out_fail;
    logic          r_out_last, n_out_last;

    logic [QW-1:0] r_elem_mem [BATCH];
    logic [QW-1:0] r_pref_mem [BATCH];
    logic [QW-1:0] r_e_q;
    logic [QW-1:0] r_p_q;

    logic          e_we, p_we;
    logic [AW-1:0] e_wa, p_wa, e_ra, p_ra;
    logic [QW-1:0] e_wd, p_wd;

    t_mm_req       mm_req;
    t_mm_rsp       mm_rsp;

    logic             accept;
    logic [AW_IN-1:0] canon_in;
    logic             batch_end;

    bmi_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // offset binary plus CanonOffset adds a multiple of q (10*q) and keeps the value positive
    assign canon_in  = AW_IN'({~i_value[15], i_value[14:0]}) + CanonOffset;
    assign batch_end = (r_ld_cnt == AW'(BATCH - 1));

    assign e_ra = (r_state == S_IDLE) ? r_rd_cnt : r_idx;
    assign p_ra = r_idx - AW'(1);

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_ld_cnt   = r_ld_cnt;
        n_rd_cnt   = r_rd_cnt;
        n_idx      = r_idx;
        n_bit      = r_bit;
        n_acc      = r_acc;
        n_prev     = r_prev;
        n_elem     = r_elem;
        n_fail     = r_fail;
        n_out_vld  = 1'b0;
        n_out_fail = r_out_fail;
        n_out_last = r_out_last;
        mm_req     = '0;
        e_we       = 1'b0;
        e_wa       = r_ld_cnt;
        e_wd       = mm_rsp.result;
        p_we       = 1'b0;
        p_wa       = r_ld_cnt;
        p_wd       = mm_rsp.result;

        unique case (r_state)
            S_IDLE: begin
                if (accept && r_phase == PH_LOAD && !i_func) begin
                    mm_req.go    = 1'b1;
                    mm_req.canon = 1'b1;
                    mm_req.a     = canon_in;
                    n_state      = S_CANON;
                end else if (accept && r_phase == PH_READ && i_func) begin
                    n_out_vld  = 1'b1;
                    n_out_fail = r_fail;
                    n_out_last = (r_rd_cnt == AW'(BATCH - 1));
                    if (r_rd_cnt == AW'(BATCH - 1)) begin
                        n_phase  = PH_LOAD;
                        n_ld_cnt = '0;
                        n_rd_cnt = '0;
                    end else begin
                        n_rd_cnt = r_rd_cnt + AW'(1);
                    end
                end
            end
            S_CANON: begin
                if (mm_rsp.done) begin
                    e_we = 1'b1;
                    if (r_ld_cnt == '0) begin
                        p_we     = 1'b1;
                        n_prev   = mm_rsp.result;
                        n_ld_cnt = r_ld_cnt + AW'(1);
                        n_state  = S_IDLE;
                    end else begin
                        mm_req.go = 1'b1;
                        mm_req.a  = AW_IN'(r_prev);
                        mm_req.b  = mm_rsp.result;
                        n_state   = S_PREF;
                    end
                end
            end
            S_PREF: begin
                if (mm_rsp.done) begin
                    p_we   = 1'b1;
                    n_prev = mm_rsp.result;
                    if (!batch_end) begin
                        n_ld_cnt = r_ld_cnt + AW'(1);
                        n_state  = S_IDLE;
                    end else if (mm_rsp.result == '0) begin
                        // a zero element: the whole batch fails
                        n_fail   = 1'b1;
                        n_phase  = PH_READ;
                        n_rd_cnt = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_fail    = 1'b0;
                        n_bit     = 4'(QW - 1);
                        mm_req.go = 1'b1;
                        mm_req.a  = AW_IN'(1);
                        mm_req.b  = QW'(1);
                        n_state   = S_ESQR;
                    end
                end
            end
            S_ESQR: begin
                if (mm_rsp.done) begin
                    n_acc = mm_rsp.result;
                    if (ExpQm2[r_bit]) begin
                        mm_req.go = 1'b1;
                        mm_req.a  = AW_IN'(mm_rsp.result);
                        mm_req.b  = r_prev;
                        n_state   = S_EMUL;
                    end else if (r_bit == '0) begin
                        n_idx   = AW'(BATCH - 1);
                        n_state = S_BRD;
                    end else begin
                        n_bit     = r_bit - 4'd1;
                        mm_req.go = 1'b1;
                        mm_req.a  = AW_IN'(mm_rsp.result);
                        mm_req.b  = mm_rsp.result;
                    end
                end
            end
            S_EMUL: begin
                if (mm_rsp.done) begin
                    n_acc = mm_rsp.result;
                    if (r_bit == '0) begin
                        n_idx   = AW'(BATCH - 1);
                        n_state = S_BRD;
                    end else begin
                        n_bit     = r_bit - 4'd1;
                        mm_req.go = 1'b1;
                        mm_req.a  = AW_IN'(mm_rsp.result);
                        mm_req.b  = mm_rsp.result;
                        n_state   = S_ESQR;
                    end
                end
            end
            S_BRD: begin
                n_state = S_BMUL;
            end
            S_BMUL: begin
                n_elem    = r_e_q;
                mm_req.go = 1'b1;
                mm_req.a  = AW_IN'(r_p_q);
                mm_req.b  = r_acc;
                n_state   = S_BW1;
            end
            S_BW1: begin
                if (mm_rsp.done) begin
                    e_we      = 1'b1;
                    e_wa      = r_idx;
                    mm_req.go = 1'b1;
                    mm_req.a  = AW_IN'(r_acc);
                    mm_req.b  = r_elem;
                    n_state   = S_BW2;
                end
            end
            S_BW2: begin
                if (mm_rsp.done) begin
                    n_acc = mm_rsp.result;
                    if (r_idx == AW'(1)) begin
                        e_we     = 1'b1;
                        e_wa     = '0;
                        n_phase  = PH_READ;
                        n_rd_cnt = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = S_BRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_LOAD;
            r_ld_cnt   <= '0;
            r_rd_cnt   <= '0;
            r_fail     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_ld_cnt   <= n_ld_cnt;
            r_rd_cnt   <= n_rd_cnt;
            r_fail     <= n_fail;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_bit      <= n_bit;
        r_acc      <= n_acc;
        r_prev     <= n_prev;
        r_elem     <= n_elem;
        r_out_fail <= n_out_fail;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            r_elem_mem[e_wa] <= e_wd;
        end
        r_e_q <= r_elem_mem[e_ra];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pref_mem[p_wa] <= p_wd;
        end
        r_p_q <= r_pref_mem[p_ra];
    end

    assign o_strobe  = r_out_vld;
    assign o_inverse = r_out_fail ? '0 : r_e_q;
    assign o_fail    = r_out_fail;
    assign o_last    = r_out_last;

    `ASSERT_CLK(a_strobe_from_read, i_clk, i_rst_n, o_strobe |-> $past(accept && i_func), "result without read transaction")
    `ASSERT_NEVER(a_strobe_busy, i_clk, i_rst_n, o_strobe && busy, "result during batch work")
    `ASSERT_CLK(a_inverse_range, i_clk, i_rst_n, o_strobe |-> (o_inverse < ModQ), "inverse not reduced")
    `ASSERT_NEVER(a_busy_in_read, i_clk, i_rst_n, busy && (r_phase == PH_READ), "work while reading")

endmodule

// ===== src/bmi_modmul.sv =====
`timescale 1ns / 1ps

module bmi_modmul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bmi_pkg::t_mm_req i_req,
    output bmi_pkg::t_mm_rsp o_rsp
);
    import bmi_pkg::*;
    `include "assert_macros.svh"

    logic [PW-1:0]           r_p;
    logic [PW-1:0]           r_p1;
    logic [12:0]             r_t;
    logic [12:0]             r_r;
    logic [QW-1:0]           r_res;
    logic                    r_v0, r_v1, r_v2, r_v3;

    logic [PW-1:0]           n_p;
    logic [PW+BarrettMW-1:0] bar_prod;
    logic [PW-1:0]           tq;
    logic [PW-1:0]           diff;

    always_comb begin
        if (i_req.canon) begin
            n_p = PW'(i_req.a);
        end else begin
            n_p = PW'(i_req.a[QW-1:0]) * PW'(i_req.b);
        end
    end

    // barrett estimate of the quotient, at most one below the true one
    assign bar_prod = (PW+BarrettMW)'(r_p) * (PW+BarrettMW)'(BarrettM);
    assign tq       = PW'(r_t) * PW'(ModQ);
    assign diff     = r_p1 - tq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= i_req.go;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p  <= n_p;
        r_t  <= bar_prod[BarrettShift+12:BarrettShift];
        r_p1 <= r_p;
        r_r  <= diff[12:0];
        if (r_r >= 13'(ModQ)) begin
            r_res <= QW'(r_r - 13'(ModQ));
        end else begin
            r_res <= r_r[QW-1:0];
        end
    end

    assign o_rsp.done   = r_v3;
    assign o_rsp.result = r_res;

    `ASSERT_CLK(a_done_latency, i_clk, i_rst_n, o_rsp.done |-> $past(i_req.go, 4), "done without request")
    `ASSERT_CLK(a_result_range, i_clk, i_rst_n, o_rsp.done |-> (o_rsp.result < ModQ), "result not reduced")
    `ASSERT_NEVER(a_no_overlap, i_clk, i_rst_n, i_req.go && (r_v0 || r_v1 || r_v2), "request while unit busy")

endmodule
